### rtl/wis_pkg.sv
package wis_pkg;

  localparam int TIME_W = 16;
  localparam int SUM_W  = 22;
  localparam int IDX_W  = 6;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] weight;
  } iv_t;

  localparam int IV_W = $bits(iv_t);

  typedef struct packed {
    logic              chosen;
    logic [IDX_W-1:0]  interval_index;
    logic [TIME_W-1:0] chosen_start;
    logic [TIME_W-1:0] chosen_end;
    logic [TIME_W-1:0] chosen_weight;
    logic [SUM_W-1:0]  best_total;
    logic              last_result;
  } res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DP_RD,
    ST_DP_LATCH,
    ST_DP_SCAN,
    ST_DP_WR,
    ST_TB_RD,
    ST_TB_CHK,
    ST_FINISH
  } st_t;

endpackage

### rtl/wis_if.sv
interface wis_in_if;
  import wis_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] weight;
  logic              last_item;

  modport source (output valid, start_time, end_time, weight, last_item, input ready);
  modport sink (input valid, start_time, end_time, weight, last_item, output ready);
endinterface

interface wis_out_if;
  import wis_pkg::*;
  logic              valid;
  logic              ready;
  logic              chosen;
  logic [IDX_W-1:0]  interval_index;
  logic [TIME_W-1:0] chosen_start;
  logic [TIME_W-1:0] chosen_end;
  logic [TIME_W-1:0] chosen_weight;
  logic [SUM_W-1:0]  best_total;
  logic              last_result;

  modport source (output valid, chosen, interval_index, chosen_start, chosen_end,
                  chosen_weight, best_total, last_result, input ready);
  modport sink (input valid, chosen, interval_index, chosen_start, chosen_end,
                chosen_weight, best_total, last_result, output ready);
endinterface

### rtl/wis_ram.sv
module wis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/weighted_interval_schedule_unit.sv
// Weighted interval scheduling engine.
// in_ch takes intervals (start, end, weight), sorted by end time, one item per
// cycle while loading. The item with last_item=1 closes the set and starts the
// compute; in_ch.ready stays low until the set is finished. Items beyond
// MAX_INTERVALS are dropped, but a last_item among them still starts compute.
// Compute: for each interval i the engine scans all earlier intervals, one
// per cycle through the single read port of each memory. Traceback then
// walks the entries from the last one down, reading and then checking each
// entry, until the remainder reaches zero or the first entry is passed.
// out_ch delivers the chosen intervals latest first; the last one carries
// last_result. A set with zero total gives one item with chosen=0.
// Results go through a one-entry hold stage and an output register; a stall
// on out_ch pauses the traceback, and after the final result is registered
// the next set can load while it still waits to be taken.
// Reset (synchronous, rst_n low) clears the control state and the load
// count; memory contents are not cleared and need no clearing pass.
module weighted_interval_schedule_unit
  import wis_pkg::*;
#(
  parameter int MAX_INTERVALS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  wis_in_if.sink    in_ch,
  wis_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  st_t             state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic            scan_pend_r, scan_pend_nxt;
  logic [TIME_W-1:0] start_i_r, start_i_nxt;
  logic [TIME_W-1:0] weight_i_r, weight_i_nxt;
  logic [SUM_W-1:0]  best_prev_r, best_prev_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0] bound_r, bound_nxt;
  logic            have_bound_r, have_bound_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [AW-1:0]   pend_idx_r, pend_idx_nxt;
  iv_t             pend_iv_r, pend_iv_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r, out_res_nxt;

  logic            iv_wr_en, iv_rd_en, bs_wr_en, bs_rd_en;
  logic [AW-1:0]   iv_wr_addr, rd_addr, bs_wr_addr;
  logic [IV_W-1:0] iv_rd_data;
  logic [SUM_W-1:0] bs_wr_data, bs_rd_data;
  iv_t             iv_in, iv_rd;
  logic            out_free, hit;
  logic [SUM_W-1:0] sum;
  logic [AW-1:0]   tb_idx;

  assign iv_in.start_time = in_ch.start_time;
  assign iv_in.end_time   = in_ch.end_time;
  assign iv_in.weight     = in_ch.weight;
  assign iv_rd            = iv_t'(iv_rd_data);

  wis_ram #(.WIDTH(IV_W), .DEPTH(MAX_INTERVALS)) u_iv_ram (
    .clk     (clk),
    .wr_en   (iv_wr_en),
    .wr_addr (iv_wr_addr),
    .wr_data (iv_in),
    .rd_en   (iv_rd_en),
    .rd_addr (rd_addr),
    .rd_data (iv_rd_data)
  );

  wis_ram #(.WIDTH(SUM_W), .DEPTH(MAX_INTERVALS)) u_bs_ram (
    .clk     (clk),
    .wr_en   (bs_wr_en),
    .wr_addr (bs_wr_addr),
    .wr_data (bs_wr_data),
    .rd_en   (bs_rd_en),
    .rd_addr (rd_addr),
    .rd_data (bs_rd_data)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign sum      = SUM_W'(weight_i_r) + best_prev_r;
  assign tb_idx   = AW'(i_r - CW'(1));
  assign hit      = (bs_rd_data == rem_r) &&
                    (!have_bound_r || (iv_rd.end_time <= bound_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      scan_pend_r <= scan_pend_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    start_i_r    <= start_i_nxt;
    weight_i_r   <= weight_i_nxt;
    best_prev_r  <= best_prev_nxt;
    total_r      <= total_nxt;
    rem_r        <= rem_nxt;
    bound_r      <= bound_nxt;
    have_bound_r <= have_bound_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_iv_r    <= pend_iv_nxt;
    out_res_r    <= out_res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    scan_pend_nxt  = scan_pend_r;
    start_i_nxt    = start_i_r;
    weight_i_nxt   = weight_i_r;
    best_prev_nxt  = best_prev_r;
    total_nxt      = total_r;
    rem_nxt        = rem_r;
    bound_nxt      = bound_r;
    have_bound_nxt = have_bound_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_iv_nxt    = pend_iv_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_res_nxt    = out_res_r;
    iv_wr_en       = 1'b0;
    iv_wr_addr     = AW'(cnt_r);
    iv_rd_en       = 1'b0;
    bs_rd_en       = 1'b0;
    bs_wr_en       = 1'b0;
    bs_wr_addr     = AW'(i_r);
    bs_wr_data     = sum;
    rd_addr        = AW'(i_r);
    in_ch.ready    = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (cnt_r < CW'(MAX_INTERVALS)) begin
            iv_wr_en = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
          if (in_ch.last_item) begin
            i_nxt     = '0;
            total_nxt = '0;
            state_nxt = ST_DP_RD;
          end
        end
      end
      ST_DP_RD: begin
        iv_rd_en  = 1'b1;
        state_nxt = ST_DP_LATCH;
      end
      ST_DP_LATCH: begin
        start_i_nxt   = iv_rd.start_time;
        weight_i_nxt  = iv_rd.weight;
        best_prev_nxt = '0;
        j_nxt         = '0;
        scan_pend_nxt = 1'b0;
        state_nxt     = ST_DP_SCAN;
      end
      ST_DP_SCAN: begin
        // read of entry j issued last cycle is compared now
        if (scan_pend_r && (iv_rd.end_time <= start_i_r) && (bs_rd_data > best_prev_r)) begin
          best_prev_nxt = bs_rd_data;
        end
        if (j_r < i_r) begin
          rd_addr       = AW'(j_r);
          iv_rd_en      = 1'b1;
          bs_rd_en      = 1'b1;
          j_nxt         = j_r + CW'(1);
          scan_pend_nxt = 1'b1;
        end else begin
          scan_pend_nxt = 1'b0;
          if (!scan_pend_r) begin
            state_nxt = ST_DP_WR;
          end
        end
      end
      ST_DP_WR: begin
        bs_wr_en = 1'b1;
        if (sum > total_r) begin
          total_nxt = sum;
        end
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == cnt_r) begin
          rem_nxt        = (sum > total_r) ? sum : total_r;
          have_bound_nxt = 1'b0;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_TB_RD;
        end else begin
          state_nxt = ST_DP_RD;
        end
      end
      ST_TB_RD: begin
        if ((rem_r == '0) || (i_r == '0)) begin
          state_nxt = ST_FINISH;
        end else begin
          rd_addr   = tb_idx;
          iv_rd_en  = 1'b1;
          bs_rd_en  = 1'b1;
          state_nxt = ST_TB_CHK;
        end
      end
      ST_TB_CHK: begin
        if (!hit) begin
          i_nxt     = i_r - CW'(1);
          state_nxt = ST_TB_RD;
        end else if (!pend_v_r || out_free) begin
          // the held result is known not to be last once a newer one is found
          if (pend_v_r) begin
            out_valid_nxt              = 1'b1;
            out_res_nxt.chosen         = 1'b1;
            out_res_nxt.interval_index = IDX_W'(pend_idx_r);
            out_res_nxt.chosen_start   = pend_iv_r.start_time;
            out_res_nxt.chosen_end     = pend_iv_r.end_time;
            out_res_nxt.chosen_weight  = pend_iv_r.weight;
            out_res_nxt.best_total     = total_r;
            out_res_nxt.last_result    = 1'b0;
          end
          pend_v_nxt     = 1'b1;
          pend_idx_nxt   = tb_idx;
          pend_iv_nxt    = iv_rd;
          rem_nxt        = (SUM_W'(iv_rd.weight) <= rem_r) ? rem_r - SUM_W'(iv_rd.weight) : '0;
          bound_nxt      = iv_rd.start_time;
          have_bound_nxt = 1'b1;
          i_nxt          = i_r - CW'(1);
          state_nxt      = ST_TB_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_res_nxt.chosen         = pend_v_r;
          out_res_nxt.interval_index = pend_v_r ? IDX_W'(pend_idx_r) : '0;
          out_res_nxt.chosen_start   = pend_v_r ? pend_iv_r.start_time : '0;
          out_res_nxt.chosen_end     = pend_v_r ? pend_iv_r.end_time : '0;
          out_res_nxt.chosen_weight  = pend_v_r ? pend_iv_r.weight : '0;
          out_res_nxt.best_total     = total_r;
          out_res_nxt.last_result    = 1'b1;
          pend_v_nxt                 = 1'b0;
          cnt_nxt                    = '0;
          state_nxt                  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.chosen         = out_res_r.chosen;
  assign out_ch.interval_index = out_res_r.interval_index;
  assign out_ch.chosen_start   = out_res_r.chosen_start;
  assign out_ch.chosen_end     = out_res_r.chosen_end;
  assign out_ch.chosen_weight  = out_res_r.chosen_weight;
  assign out_ch.best_total     = out_res_r.best_total;
  assign out_ch.last_result    = out_res_r.last_result;

  // an empty selection only happens for a zero total and always closes the set
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.chosen |-> out_ch.last_result && (out_ch.best_total == '0))
    else $error("unchosen result with nonzero total or not last");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DP_SCAN |-> j_r <= i_r)
    else $error("dp scan index ran past current interval");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_RD || state_r == ST_TB_CHK) |-> rem_r <= total_r)
    else $error("traceback remainder exceeds total");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (state_r == ST_LOAD) && (cnt_r == '0))
    else $error("set did not restart after final result");

endmodule
